FILE: rtl/core/bpt_pkg.sv
// ----------------------------------------------------------------------------
// bpt_pkg
// shared types and constants of the barycentric point-in-triangle block
// ----------------------------------------------------------------------------
package bpt_pkg;

   // coordinate and intermediate widths
   localparam int COORD_WIDTH = 24;
   localparam int DIFF_W      = COORD_WIDTH + 1;     // edge and offset vectors
   localparam int PROD_W      = 2 * DIFF_W;          // one component product
   localparam int DOT_W       = PROD_W + 1;          // sum of three products
   localparam int SPLIT       = 26;                  // low half of a wide multiply
   localparam int HH_W        = 2 * (DOT_W - SPLIT); // high x high partial
   localparam int LH_W        = DOT_W + 1;           // low x high partial
   localparam int LL_W        = 2 * SPLIT;           // low x low partial
   localparam int MUL_W       = 2 * DOT_W;           // full wide product
   localparam int NUM_W       = MUL_W + 1;           // denominator and numerators
   localparam int WEIGHT_W    = 32;

   // configuration port
   localparam int THR_W       = 40;
   localparam int TOL_W       = 25;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_SEL_BIT = 3;

   localparam logic [THR_W-1:0] DEGEN_THR_RESET  = 40'd28147;
   localparam logic [TOL_W-1:0] INSIDE_TOL_RESET = 25'd1678;

   typedef enum logic {
      CSR_DEGEN_THR  = 1'b0,
      CSR_INSIDE_TOL = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] point_z;
      logic signed [COORD_WIDTH-1:0] a_x;
      logic signed [COORD_WIDTH-1:0] a_y;
      logic signed [COORD_WIDTH-1:0] a_z;
      logic signed [COORD_WIDTH-1:0] b_x;
      logic signed [COORD_WIDTH-1:0] b_y;
      logic signed [COORD_WIDTH-1:0] b_z;
      logic signed [COORD_WIDTH-1:0] c_x;
      logic signed [COORD_WIDTH-1:0] c_y;
      logic signed [COORD_WIDTH-1:0] c_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [WEIGHT_W-1:0] weight_a;
      logic signed [WEIGHT_W-1:0] weight_b;
      logic signed [WEIGHT_W-1:0] weight_c;
      logic                       inside_res;
      logic                       degenerate;
   } rsp_payload_type;

   // status that rides along with an item through the divider and back end
   typedef struct packed {
      logic valid;
      logic degen;
      logic neg_b;
      logic neg_c;
   } div_ctrl_type;

endpackage

FILE: rtl/core/bpt_div.sv
// ----------------------------------------------------------------------------
// bpt_div
// two-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module bpt_div #(
   parameter int WEIGHT_FRAC = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  bpt_pkg::div_ctrl_type          in_ctrl,
   input  logic [bpt_pkg::NUM_W-1:0]      in_den,
   input  logic [bpt_pkg::NUM_W-1:0]      in_mag_b,
   input  logic [bpt_pkg::NUM_W-1:0]      in_mag_c,
   output bpt_pkg::div_ctrl_type          out_ctrl,
   output logic [2*bpt_pkg::DIFF_W+WEIGHT_FRAC:0] out_q_b,
   output logic [2*bpt_pkg::DIFF_W+WEIGHT_FRAC:0] out_q_c,
   output logic                           out_rnd_b,
   output logic                           out_rnd_c
);

   localparam int NW = bpt_pkg::NUM_W;
   localparam int HI = 2 * bpt_pkg::DIFF_W + 1;   // quotient bits above the fraction
   localparam int QW = HI + WEIGHT_FRAC;           // quotient bits and stages

   bpt_pkg::div_ctrl_type ctrl_ff [QW];
   bpt_pkg::div_ctrl_type ctrl_in [QW];
   logic [NW-1:0] den_ff   [QW];
   logic [NW-1:0] den_in   [QW];
   logic [NW-1:0] rem_b_ff [QW];
   logic [NW-1:0] rem_b_in [QW];
   logic [NW-1:0] rem_c_ff [QW];
   logic [NW-1:0] rem_c_in [QW];
   logic [QW-1:0] sh_b_ff  [QW];
   logic [QW-1:0] sh_b_in  [QW];
   logic [QW-1:0] sh_c_ff  [QW];
   logic [QW-1:0] sh_c_in  [QW];

   // dividend bits shift out at the top, quotient bits shift in at the bottom
   always_comb begin
      bpt_pkg::div_ctrl_type src_ctrl;
      logic [NW-1:0] src_den;
      logic [NW-1:0] src_rem_b;
      logic [NW-1:0] src_rem_c;
      logic [QW-1:0] src_sh_b;
      logic [QW-1:0] src_sh_c;
      logic [NW:0]   trial_b;
      logic [NW:0]   trial_c;
      logic          bit_b;
      logic          bit_c;
      for (int s = 0; s < QW; s++) begin
         if (s == 0) begin
            src_ctrl  = in_ctrl;
            src_den   = in_den;
            src_rem_b = in_mag_b >> HI;
            src_rem_c = in_mag_c >> HI;
            src_sh_b  = {in_mag_b[HI-1:0], {WEIGHT_FRAC{1'b0}}};
            src_sh_c  = {in_mag_c[HI-1:0], {WEIGHT_FRAC{1'b0}}};
         end else begin
            src_ctrl  = ctrl_ff[s-1];
            src_den   = den_ff[s-1];
            src_rem_b = rem_b_ff[s-1];
            src_rem_c = rem_c_ff[s-1];
            src_sh_b  = sh_b_ff[s-1];
            src_sh_c  = sh_c_ff[s-1];
         end
         trial_b = {src_rem_b, src_sh_b[QW-1]};
         trial_c = {src_rem_c, src_sh_c[QW-1]};
         bit_b   = (trial_b >= {1'b0, src_den});
         bit_c   = (trial_c >= {1'b0, src_den});
         if (bit_b) begin
            rem_b_in[s] = NW'(trial_b - {1'b0, src_den});
         end else begin
            rem_b_in[s] = trial_b[NW-1:0];
         end
         if (bit_c) begin
            rem_c_in[s] = NW'(trial_c - {1'b0, src_den});
         end else begin
            rem_c_in[s] = trial_c[NW-1:0];
         end
         sh_b_in[s] = {src_sh_b[QW-2:0], bit_b};
         sh_c_in[s] = {src_sh_c[QW-2:0], bit_c};
         ctrl_in[s] = src_ctrl;
         den_in[s]  = src_den;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < QW; s++) begin
            ctrl_ff[s] <= '0;
         end
      end else if (adv) begin
         for (int s = 0; s < QW; s++) begin
            ctrl_ff[s] <= ctrl_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < QW; s++) begin
            den_ff[s]   <= den_in[s];
            rem_b_ff[s] <= rem_b_in[s];
            rem_c_ff[s] <= rem_c_in[s];
            sh_b_ff[s]  <= sh_b_in[s];
            sh_c_ff[s]  <= sh_c_in[s];
         end
      end
   end

   // round half away from zero on the magnitude
   assign out_ctrl  = ctrl_ff[QW-1];
   assign out_q_b   = sh_b_ff[QW-1];
   assign out_q_c   = sh_c_ff[QW-1];
   assign out_rnd_b = ({rem_b_ff[QW-1], 1'b0} >= {1'b0, den_ff[QW-1]});
   assign out_rnd_c = ({rem_c_ff[QW-1], 1'b0} >= {1'b0, den_ff[QW-1]});

endmodule

FILE: rtl/core/barycentric_point_in_triangle.sv
// ----------------------------------------------------------------------------
// barycentric_point_in_triangle
// throughput: one item per cycle while the skid entry is empty; the divider retires one quotient bit per stage
// a two-entry output buffer lets input transfers continue while rsp_ready is low;
// the pipeline holds only once the second entry is full
// reset: synchronous, clears all valid bits and loads register reset values
// ----------------------------------------------------------------------------
module barycentric_point_in_triangle #(
   parameter int WEIGHT_FRAC = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bpt_pkg::req_payload_type          req_data,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bpt_pkg::rsp_payload_type          rsp_data,
   // register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [bpt_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [bpt_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [bpt_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   localparam int CW     = bpt_pkg::COORD_WIDTH;
   localparam int DW     = bpt_pkg::DIFF_W;
   localparam int PW     = bpt_pkg::PROD_W;
   localparam int TW     = bpt_pkg::DOT_W;
   localparam int SP     = bpt_pkg::SPLIT;
   localparam int MW     = bpt_pkg::MUL_W;
   localparam int NW     = bpt_pkg::NUM_W;
   localparam int OW     = bpt_pkg::WEIGHT_W;
   localparam int QW     = 2 * DW + 1 + WEIGHT_FRAC;   // quotient width
   localparam int WW     = QW + 2;                     // signed rounded weight
   localparam int AW     = WW + 1;                     // first weight before clamp
   localparam int FRONT  = 6;                          // stages ahead of the divider ctrl

   // operand selection of the six wide products
   // dots: 0 d00, 1 d01, 2 d11, 3 d20, 4 d21
   localparam int MUL_A [6] = '{0, 1, 2, 1, 0, 1};
   localparam int MUL_B [6] = '{2, 1, 3, 4, 4, 3};

   // ---------------------------------------------------------------------
   // register port
   // ---------------------------------------------------------------------
   logic [bpt_pkg::THR_W-1:0] thr_ff, thr_in;
   logic [bpt_pkg::TOL_W-1:0] tol_ff, tol_in;
   logic                      csr_wr;
   bpt_pkg::csr_index_type    csr_index;

   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite;
   assign csr_index = bpt_pkg::csr_index_type'(paddr[bpt_pkg::CSR_SEL_BIT]);

   always_comb begin
      thr_in = thr_ff;
      tol_in = tol_ff;
      if (csr_wr) begin
         unique case (csr_index)
            bpt_pkg::CSR_DEGEN_THR:  thr_in = pwdata[bpt_pkg::THR_W-1:0];
            bpt_pkg::CSR_INSIDE_TOL: tol_in = pwdata[bpt_pkg::TOL_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         bpt_pkg::CSR_DEGEN_THR:  prdata = bpt_pkg::CSR_DATA_W'(thr_ff);
         bpt_pkg::CSR_INSIDE_TOL: prdata = bpt_pkg::CSR_DATA_W'(tol_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= bpt_pkg::DEGEN_THR_RESET;
         tol_ff <= bpt_pkg::INSIDE_TOL_RESET;
      end else begin
         thr_ff <= thr_in;
         tol_ff <= tol_in;
      end
   end

   // ---------------------------------------------------------------------
   // flow control: the whole pipeline moves unless the output skid is full
   // ---------------------------------------------------------------------
   logic adv;
   logic skid_valid_ff, skid_valid_in;

   assign adv       = !skid_valid_ff;
   assign req_ready = adv;

   logic [FRONT-1:0] front_valid_ff, front_valid_in;

   assign front_valid_in = {front_valid_ff[FRONT-2:0], req_valid && adv};

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= '0;
      end else if (adv) begin
         front_valid_ff <= front_valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // stage 1: edge vectors e0 = b - a, e1 = c - a and offset v = p - a
   // ---------------------------------------------------------------------
   logic signed [CW-1:0] pt [3];
   logic signed [CW-1:0] va [3];
   logic signed [CW-1:0] vb [3];
   logic signed [CW-1:0] vc [3];
   logic signed [DW-1:0] s1_e0_ff [3], s1_e0_in [3];
   logic signed [DW-1:0] s1_e1_ff [3], s1_e1_in [3];
   logic signed [DW-1:0] s1_v_ff  [3], s1_v_in  [3];

   always_comb begin
      pt[0] = req_data.point_x;  pt[1] = req_data.point_y;  pt[2] = req_data.point_z;
      va[0] = req_data.a_x;      va[1] = req_data.a_y;      va[2] = req_data.a_z;
      vb[0] = req_data.b_x;      vb[1] = req_data.b_y;      vb[2] = req_data.b_z;
      vc[0] = req_data.c_x;      vc[1] = req_data.c_y;      vc[2] = req_data.c_z;
      for (int i = 0; i < 3; i++) begin
         s1_e0_in[i] = DW'(vb[i]) - DW'(va[i]);
         s1_e1_in[i] = DW'(vc[i]) - DW'(va[i]);
         s1_v_in[i]  = DW'(pt[i]) - DW'(va[i]);
      end
   end

   // ---------------------------------------------------------------------
   // stage 2: fifteen component products of the five dot products
   // ---------------------------------------------------------------------
   logic signed [PW-1:0] s2_prod_ff [15], s2_prod_in [15];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_prod_in[i]      = s1_e0_ff[i] * s1_e0_ff[i];
         s2_prod_in[3 + i]  = s1_e0_ff[i] * s1_e1_ff[i];
         s2_prod_in[6 + i]  = s1_e1_ff[i] * s1_e1_ff[i];
         s2_prod_in[9 + i]  = s1_v_ff[i]  * s1_e0_ff[i];
         s2_prod_in[12 + i] = s1_v_ff[i]  * s1_e1_ff[i];
      end
   end

   // ---------------------------------------------------------------------
   // stage 3: dot products d00, d01, d11, d20, d21
   // ---------------------------------------------------------------------
   logic signed [TW-1:0] s3_dot_ff [5], s3_dot_in [5];

   always_comb begin
      for (int j = 0; j < 5; j++) begin
         s3_dot_in[j] = TW'(s2_prod_ff[3*j]) + TW'(s2_prod_ff[3*j + 1])
                      + TW'(s2_prod_ff[3*j + 2]);
      end
   end

   // ---------------------------------------------------------------------
   // stage 4: partial products of the six wide multiplies
   // low halves unsigned, high halves signed
   // ---------------------------------------------------------------------
   logic        [bpt_pkg::LL_W-1:0] s4_ll_ff [6], s4_ll_in [6];
   logic signed [bpt_pkg::LH_W-1:0] s4_lh_ff [6], s4_lh_in [6];
   logic signed [bpt_pkg::LH_W-1:0] s4_hl_ff [6], s4_hl_in [6];
   logic signed [bpt_pkg::HH_W-1:0] s4_hh_ff [6], s4_hh_in [6];

   always_comb begin
      logic        [SP-1:0]    lo_a;
      logic        [SP-1:0]    lo_b;
      logic signed [TW-SP-1:0] hi_a;
      logic signed [TW-SP-1:0] hi_b;
      for (int m = 0; m < 6; m++) begin
         lo_a = s3_dot_ff[MUL_A[m]][SP-1:0];
         lo_b = s3_dot_ff[MUL_B[m]][SP-1:0];
         hi_a = $signed(s3_dot_ff[MUL_A[m]][TW-1:SP]);
         hi_b = $signed(s3_dot_ff[MUL_B[m]][TW-1:SP]);
         s4_ll_in[m] = lo_a * lo_b;
         s4_lh_in[m] = $signed({1'b0, lo_a}) * hi_b;
         s4_hl_in[m] = $signed({1'b0, lo_b}) * hi_a;
         s4_hh_in[m] = hi_a * hi_b;
      end
   end

   // ---------------------------------------------------------------------
   // stage 5: assemble the wide products
   // ---------------------------------------------------------------------
   logic signed [MW-1:0] s5_mul_ff [6], s5_mul_in [6];

   always_comb begin
      for (int m = 0; m < 6; m++) begin
         s5_mul_in[m] = (MW'(s4_hh_ff[m]) << (2 * SP))
                      + ((MW'(s4_lh_ff[m]) + MW'(s4_hl_ff[m])) << SP)
                      + MW'(s4_ll_ff[m]);
      end
   end

   // ---------------------------------------------------------------------
   // stage 6: denominator and the two numerators
   // den = d00*d11 - d01^2 is a squared cross product, never negative
   // ---------------------------------------------------------------------
   logic signed [NW-1:0] s6_den_ff,   s6_den_in;
   logic signed [NW-1:0] s6_num_b_ff, s6_num_b_in;
   logic signed [NW-1:0] s6_num_c_ff, s6_num_c_in;

   always_comb begin
      s6_den_in   = NW'(s5_mul_ff[0]) - NW'(s5_mul_ff[1]);
      s6_num_b_in = NW'(s5_mul_ff[2]) - NW'(s5_mul_ff[3]);
      s6_num_c_in = NW'(s5_mul_ff[4]) - NW'(s5_mul_ff[5]);
   end

   // ---------------------------------------------------------------------
   // stage 7: degenerate test, numerator magnitudes and quotient signs
   // ---------------------------------------------------------------------
   bpt_pkg::div_ctrl_type s7_ctrl_ff, s7_ctrl_in;
   logic [NW-1:0] s7_den_ff,   s7_den_in;
   logic [NW-1:0] s7_mag_b_ff, s7_mag_b_in;
   logic [NW-1:0] s7_mag_c_ff, s7_mag_c_in;

   always_comb begin
      s7_ctrl_in.valid = front_valid_ff[FRONT-1];
      s7_ctrl_in.degen = (s6_den_ff == '0) || (s6_den_ff < NW'(thr_ff));
      s7_ctrl_in.neg_b = s6_num_b_ff[NW-1];
      s7_ctrl_in.neg_c = s6_num_c_ff[NW-1];
      s7_den_in        = s6_den_ff;
      s7_mag_b_in      = s6_num_b_ff[NW-1] ? NW'(-s6_num_b_ff) : s6_num_b_ff;
      s7_mag_c_in      = s6_num_c_ff[NW-1] ? NW'(-s6_num_c_ff) : s6_num_c_ff;
   end

   // ---------------------------------------------------------------------
   // divider: |num| * 2^WEIGHT_FRAC / den, one bit per stage
   // ---------------------------------------------------------------------
   bpt_pkg::div_ctrl_type div_ctrl;
   logic [QW-1:0]         div_q_b;
   logic [QW-1:0]         div_q_c;
   logic                  div_rnd_b;
   logic                  div_rnd_c;

   bpt_div #(
      .WEIGHT_FRAC (WEIGHT_FRAC)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_ctrl   (s7_ctrl_ff),
      .in_den    (s7_den_ff),
      .in_mag_b  (s7_mag_b_ff),
      .in_mag_c  (s7_mag_c_ff),
      .out_ctrl  (div_ctrl),
      .out_q_b   (div_q_b),
      .out_q_c   (div_q_c),
      .out_rnd_b (div_rnd_b),
      .out_rnd_c (div_rnd_c)
   );

   // ---------------------------------------------------------------------
   // stage 8: rounding and sign, -(q + r) folded into ~q + !r
   // ---------------------------------------------------------------------
   bpt_pkg::div_ctrl_type s8_ctrl_ff, s8_ctrl_in;
   logic signed [WW-1:0]  s8_wb_ff,   s8_wb_in;
   logic signed [WW-1:0]  s8_wc_ff,   s8_wc_in;

   always_comb begin
      s8_ctrl_in = div_ctrl;
      if (div_ctrl.neg_b) begin
         s8_wb_in = ~{2'b00, div_q_b} + WW'(!div_rnd_b);
      end else begin
         s8_wb_in = {2'b00, div_q_b} + WW'(div_rnd_b);
      end
      if (div_ctrl.neg_c) begin
         s8_wc_in = ~{2'b00, div_q_c} + WW'(!div_rnd_c);
      end else begin
         s8_wc_in = {2'b00, div_q_c} + WW'(div_rnd_c);
      end
   end

   // ---------------------------------------------------------------------
   // stage 9: first weight from the unclamped others, clamp b and c
   // ---------------------------------------------------------------------
   function automatic logic [OW-1:0] clamp_weight(input logic signed [AW-1:0] x);
      logic fits;
      fits = (x[AW-1:OW-1] == {(AW-OW+1){x[AW-1]}});
      if (fits) begin
         return x[OW-1:0];
      end else if (x[AW-1]) begin
         return {1'b1, {(OW-1){1'b0}}};
      end else begin
         return {1'b0, {(OW-1){1'b1}}};
      end
   endfunction

   bpt_pkg::div_ctrl_type s9_ctrl_ff, s9_ctrl_in;
   logic signed [AW-1:0]  s9_wa_ff,   s9_wa_in;
   logic        [OW-1:0]  s9_wb_ff,   s9_wb_in;
   logic        [OW-1:0]  s9_wc_ff,   s9_wc_in;

   always_comb begin
      s9_ctrl_in = s8_ctrl_ff;
      s9_wa_in   = (AW'(1) << WEIGHT_FRAC) - AW'(s8_wb_ff) - AW'(s8_wc_ff);
      s9_wb_in   = clamp_weight(AW'(s8_wb_ff));
      s9_wc_in   = clamp_weight(AW'(s8_wc_ff));
   end

   // ---------------------------------------------------------------------
   // result: clamp a, inside test, degenerate override
   // ---------------------------------------------------------------------
   bpt_pkg::rsp_payload_type result;
   logic signed [OW:0]       neg_tol;
   logic        [OW-1:0]     wa_sat;

   always_comb begin
      wa_sat  = clamp_weight(s9_wa_ff);
      neg_tol = (OW+1)'(0) - (OW+1)'(tol_ff);
      if (s9_ctrl_ff.degen) begin
         result.weight_a   = OW'(1) << WEIGHT_FRAC;
         result.weight_b   = '0;
         result.weight_c   = '0;
         result.inside_res = 1'b0;
         result.degenerate = 1'b1;
      end else begin
         result.weight_a   = wa_sat;
         result.weight_b   = s9_wb_ff;
         result.weight_c   = s9_wc_ff;
         result.inside_res = ($signed({wa_sat[OW-1], wa_sat}) >= neg_tol)
                          && ($signed({s9_wb_ff[OW-1], s9_wb_ff}) >= neg_tol)
                          && ($signed({s9_wc_ff[OW-1], s9_wc_ff}) >= neg_tol);
         result.degenerate = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // pipeline registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s7_ctrl_ff <= '0;
         s8_ctrl_ff <= '0;
         s9_ctrl_ff <= '0;
      end else if (adv) begin
         s7_ctrl_ff <= s7_ctrl_in;
         s8_ctrl_ff <= s8_ctrl_in;
         s9_ctrl_ff <= s9_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_e0_ff    <= s1_e0_in;
         s1_e1_ff    <= s1_e1_in;
         s1_v_ff     <= s1_v_in;
         s2_prod_ff  <= s2_prod_in;
         s3_dot_ff   <= s3_dot_in;
         s4_ll_ff    <= s4_ll_in;
         s4_lh_ff    <= s4_lh_in;
         s4_hl_ff    <= s4_hl_in;
         s4_hh_ff    <= s4_hh_in;
         s5_mul_ff   <= s5_mul_in;
         s6_den_ff   <= s6_den_in;
         s6_num_b_ff <= s6_num_b_in;
         s6_num_c_ff <= s6_num_c_in;
         s7_den_ff   <= s7_den_in;
         s7_mag_b_ff <= s7_mag_b_in;
         s7_mag_c_ff <= s7_mag_c_in;
         s8_wb_ff    <= s8_wb_in;
         s8_wc_ff    <= s8_wc_in;
         s9_wa_ff    <= s9_wa_in;
         s9_wb_ff    <= s9_wb_in;
         s9_wc_ff    <= s9_wc_in;
      end
   end

   // ---------------------------------------------------------------------
   // two-entry output buffer: output register plus skid entry
   // ---------------------------------------------------------------------
   logic                     out_valid_ff, out_valid_in;
   bpt_pkg::rsp_payload_type out_data_ff,  out_data_in;
   bpt_pkg::rsp_payload_type skid_data_ff, skid_data_in;
   logic                     take;
   logic                     push;

   assign take = out_valid_ff && rsp_ready;
   assign push = adv && s9_ctrl_ff.valid;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      priority if (skid_valid_ff) begin
         // pipeline is held, drain the skid entry first
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // the skid entry only fills behind an occupied output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output register");

   // skid fills only after a result was held by a stalled consumer
   a_skid_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_ready))
      else $error("skid entry filled without a stalled output");

   // a live item entering the divider has a nonzero denominator
   a_div_den: assert property (@(posedge clock) disable iff (reset)
      s7_ctrl_ff.valid && !s7_ctrl_ff.degen |-> s7_den_ff != '0)
      else $error("divider fed with zero denominator");

   // degenerate results carry zero weights b and c and a clear inside flag
   a_degen_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.weight_b == '0 && rsp_data.weight_c == '0 && !rsp_data.inside_res)
      else $error("malformed degenerate result");

endmodule
